/* hw/rtl/bpa_pkg.sv */
// Package for the buddy page allocator: sizes, result codes and sequencer states.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

    localparam int FRAME_BITS = 16;
    localparam int MAX_ORDER  = 11;
    localparam int ORD_BITS   = 4;
    localparam int NPAGES     = 1 << FRAME_BITS;
    localparam int LINK_W     = FRAME_BITS + 1;
    localparam int LINKS_W    = 2 * LINK_W;
    localparam int META_W     = ORD_BITS + 1;
    localparam int COUNT_W    = FRAME_BITS + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NOMEM  = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SPLIT,
        S_F_SET,
        S_F_LOOP,
        S_F_CHK,
        S_F_MERGE,
        S_F_END,
        S_U_RD,
        S_U_GET,
        S_U_PR,
        S_U_N0,
        S_U_N,
        S_U_CLR,
        S_P_WR,
        S_P_RD,
        S_P_UPD,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/bpa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/buddy_page_allocator_unit.sv */
// Top level of the buddy page allocator: sequencer, list heads and two state memories.
// Depends on bpa_pkg and bpa_ram.
//
// Channel   Direction  Signals
// command   in         start, operation, block_order, page_number (busy is out)
// result    out        done, status, granted_page, free_page_count
// config    in         total_pages_we, total_pages_wdata
//
// A rejected item, or an allocate that finds nothing free, goes straight to the result. A free
// does a buddy check, an unlink and a step up per merge level, at most ten levels, then a push.
// An allocate does an unlink and then a split and a push per split level. The link memory has a
// single read and a single write port, so these steps run one after another. After reset the
// page flag memory is cleared, one entry a cycle, with busy high. The result is shown for one
// cycle with done.
`timescale 1ns / 1ps
`default_nettype none
module buddy_page_allocator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [3:0]  block_order,
    input  wire logic [15:0] page_number,
    input  wire logic        total_pages_we,
    input  wire logic [16:0] total_pages_wdata,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      granted_page,
    output logic [16:0]      free_page_count
);

    localparam int FB = bpa_pkg::FRAME_BITS;
    localparam int LW = bpa_pkg::LINK_W;
    localparam int OB = bpa_pkg::ORD_BITS;

    bpa_pkg::state_t  state_reg, state_next, ret_reg, ret_next;
    bpa_pkg::status_t status_reg, status_next;
    logic [OB-1:0]    ord_reg, ord_next, cur_reg, cur_next;
    logic [FB-1:0]    pfn_reg, pfn_next, tgt_reg, tgt_next;
    logic [FB-1:0]    granted_reg, granted_next, clr_reg, clr_next;
    logic [LW-1:0]    n_reg, n_next, pr_reg, pr_next, h_reg, h_next;
    logic [LW-1:0]    heads_reg [bpa_pkg::MAX_ORDER];
    logic [LW-1:0]    heads_next [bpa_pkg::MAX_ORDER];
    logic [bpa_pkg::COUNT_W-1:0] free_reg, free_next, total_reg, total_next;

    logic                       link_we, meta_we;
    logic [FB-1:0]              link_wa, link_ra, meta_wa, meta_ra;
    logic [bpa_pkg::LINKS_W-1:0] link_wd, link_rd;
    logic [bpa_pkg::META_W-1:0] meta_wd, meta_rd;

    logic          found;
    logic [OB-1:0] found_idx;
    logic [FB-1:0] bit_cur, buddy, split_bit;
    logic [OB-1:0] cur_dec;

    // Link word: prev link in the upper half, next link in the lower half.
    bpa_ram #(.WIDTH(bpa_pkg::LINKS_W), .DEPTH(bpa_pkg::NPAGES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_wa),
        .wdata (link_wd),
        .raddr (link_ra),
        .rdata (link_rd)
    );

    // Flag word: block order above, free flag in bit zero.
    bpa_ram #(.WIDTH(bpa_pkg::META_W), .DEPTH(bpa_pkg::NPAGES)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_wa),
        .wdata (meta_wd),
        .raddr (meta_ra),
        .rdata (meta_rd)
    );

    // Lowest non-empty list at or above the requested order.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = bpa_pkg::MAX_ORDER - 1; i >= 0; i--)
        begin
            if (heads_reg[i][LW-1] && (OB'(i) >= block_order))
            begin
                found     = 1'b1;
                found_idx = OB'(i);
            end
        end
    end

    assign bit_cur   = FB'(1) << cur_reg;
    assign buddy     = pfn_reg ^ bit_cur;
    assign cur_dec   = cur_reg - OB'(1);
    assign split_bit = FB'(1) << cur_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bpa_pkg::S_CLEAR;
            ret_reg    <= bpa_pkg::S_IDLE;
            clr_reg    <= '0;
            free_reg   <= '0;
            total_reg  <= 17'(bpa_pkg::NPAGES);
            status_reg <= bpa_pkg::STATUS_OK;
            granted_reg <= '0;
            for (int i = 0; i < bpa_pkg::MAX_ORDER; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            clr_reg     <= clr_next;
            free_reg    <= free_next;
            total_reg   <= total_next;
            status_reg  <= status_next;
            granted_reg <= granted_next;
            heads_reg   <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg <= ord_next;
        cur_reg <= cur_next;
        pfn_reg <= pfn_next;
        tgt_reg <= tgt_next;
        n_reg   <= n_next;
        pr_reg  <= pr_next;
        h_reg   <= h_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        clr_next     = clr_reg;
        free_next    = free_reg;
        total_next   = total_pages_we ? total_pages_wdata : total_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        heads_next   = heads_reg;
        ord_next     = ord_reg;
        cur_next     = cur_reg;
        pfn_next     = pfn_reg;
        tgt_next     = tgt_reg;
        n_next       = n_reg;
        pr_next      = pr_reg;
        h_next       = h_reg;
        link_we      = 1'b0;
        link_wa      = tgt_reg;
        link_wd      = '0;
        link_ra      = tgt_reg;
        meta_we      = 1'b0;
        meta_wa      = pfn_reg;
        meta_wd      = '0;
        meta_ra      = pfn_reg;

        case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg;
                clr_next = clr_reg + FB'(1);
                if (clr_reg == '1)
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ord_next     = block_order;
                    pfn_next     = page_number;
                    granted_next = '0;
                    state_next   = bpa_pkg::S_DONE;
                    if (operation == bpa_pkg::OP_ALLOC)
                    begin
                        if (32'(block_order) >= bpa_pkg::MAX_ORDER)
                        begin
                            status_next = bpa_pkg::STATUS_REJECT;
                        end
                        else if (!found)
                        begin
                            status_next = bpa_pkg::STATUS_NOMEM;
                        end
                        else
                        begin
                            cur_next   = found_idx;
                            tgt_next   = heads_reg[found_idx][FB-1:0];
                            pfn_next   = heads_reg[found_idx][FB-1:0];
                            ret_next   = bpa_pkg::S_A_SPLIT;
                            state_next = bpa_pkg::S_U_RD;
                        end
                    end
                    else
                    begin
                        if ((32'(block_order) >= bpa_pkg::MAX_ORDER) || (page_number == '0)
                            || ({1'b0, page_number} >= total_reg))
                        begin
                            status_next = bpa_pkg::STATUS_REJECT;
                        end
                        else
                        begin
                            meta_ra    = page_number;
                            cur_next   = block_order;
                            state_next = bpa_pkg::S_F_SET;
                        end
                    end
                end
            end
            bpa_pkg::S_A_SPLIT:
            begin
                if (cur_reg > ord_reg)
                begin
                    meta_we    = 1'b1;
                    meta_wa    = pfn_reg ^ split_bit;
                    meta_wd    = {cur_dec, 1'b1};
                    cur_next   = cur_dec;
                    tgt_next   = pfn_reg ^ split_bit;
                    ret_next   = bpa_pkg::S_A_SPLIT;
                    state_next = bpa_pkg::S_P_WR;
                end
                else
                begin
                    meta_we      = 1'b1;
                    meta_wd      = {ord_reg, 1'b0};
                    free_next    = free_reg - (17'(1) << ord_reg);
                    granted_next = pfn_reg;
                    status_next  = bpa_pkg::STATUS_OK;
                    state_next   = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_F_SET:
            begin
                // Record the order on the original frame and keep its free flag.
                meta_we    = 1'b1;
                meta_wd    = {ord_reg, meta_rd[0]};
                state_next = bpa_pkg::S_F_LOOP;
            end
            bpa_pkg::S_F_LOOP:
            begin
                if ((32'(cur_reg) < bpa_pkg::MAX_ORDER - 1) && ({1'b0, buddy} < total_reg))
                begin
                    meta_ra    = buddy;
                    tgt_next   = buddy;
                    state_next = bpa_pkg::S_F_CHK;
                end
                else
                begin
                    state_next = bpa_pkg::S_F_END;
                end
            end
            bpa_pkg::S_F_CHK:
            begin
                if (meta_rd[0] && (meta_rd[bpa_pkg::META_W-1:1] == cur_reg))
                begin
                    meta_we    = 1'b1;
                    meta_wa    = tgt_reg;
                    meta_wd    = {cur_reg, 1'b0};
                    ret_next   = bpa_pkg::S_F_MERGE;
                    state_next = bpa_pkg::S_U_RD;
                end
                else
                begin
                    state_next = bpa_pkg::S_F_END;
                end
            end
            bpa_pkg::S_F_MERGE:
            begin
                pfn_next   = pfn_reg & ~bit_cur;
                cur_next   = cur_reg + OB'(1);
                state_next = bpa_pkg::S_F_LOOP;
            end
            bpa_pkg::S_F_END:
            begin
                meta_we     = 1'b1;
                meta_wd     = {cur_reg, 1'b1};
                free_next   = free_reg + (17'(1) << cur_reg);
                tgt_next    = pfn_reg;
                status_next = bpa_pkg::STATUS_OK;
                ret_next    = bpa_pkg::S_DONE;
                state_next  = bpa_pkg::S_P_WR;
            end
            bpa_pkg::S_U_RD:
            begin
                state_next = bpa_pkg::S_U_GET;
            end
            bpa_pkg::S_U_GET:
            begin
                n_next  = link_rd[LW-1:0];
                pr_next = link_rd[2*LW-1:LW];
                if (link_rd[2*LW-1])
                begin
                    link_ra    = link_rd[2*LW-2:LW];
                    state_next = bpa_pkg::S_U_PR;
                end
                else
                begin
                    heads_next[cur_reg] = link_rd[LW-1:0];
                    state_next          = bpa_pkg::S_U_N0;
                end
            end
            bpa_pkg::S_U_PR:
            begin
                link_we    = 1'b1;
                link_wa    = pr_reg[FB-1:0];
                link_wd    = {link_rd[2*LW-1:LW], n_reg};
                state_next = bpa_pkg::S_U_N0;
            end
            bpa_pkg::S_U_N0:
            begin
                // The read is issued only after the S_U_PR write, so it sees that write.
                if (n_reg[LW-1])
                begin
                    link_ra    = n_reg[FB-1:0];
                    state_next = bpa_pkg::S_U_N;
                end
                else
                begin
                    state_next = bpa_pkg::S_U_CLR;
                end
            end
            bpa_pkg::S_U_N:
            begin
                link_we    = 1'b1;
                link_wa    = n_reg[FB-1:0];
                link_wd    = {pr_reg, link_rd[LW-1:0]};
                state_next = bpa_pkg::S_U_CLR;
            end
            bpa_pkg::S_U_CLR:
            begin
                link_we    = 1'b1;
                state_next = ret_reg;
            end
            bpa_pkg::S_P_WR:
            begin
                link_we             = 1'b1;
                link_wd             = {{LW{1'b0}}, heads_reg[cur_reg]};
                h_next              = heads_reg[cur_reg];
                heads_next[cur_reg] = {1'b1, tgt_reg};
                state_next          = heads_reg[cur_reg][LW-1] ? bpa_pkg::S_P_RD : ret_reg;
            end
            bpa_pkg::S_P_RD:
            begin
                link_ra    = h_reg[FB-1:0];
                state_next = bpa_pkg::S_P_UPD;
            end
            bpa_pkg::S_P_UPD:
            begin
                link_we    = 1'b1;
                link_wa    = h_reg[FB-1:0];
                link_wd    = {1'b1, tgt_reg, link_rd[LW-1:0]};
                state_next = ret_reg;
            end
            bpa_pkg::S_DONE:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != bpa_pkg::S_IDLE);
    assign done            = (state_reg == bpa_pkg::S_DONE);
    assign status          = status_reg;
    assign granted_page    = granted_reg;
    assign free_page_count = free_reg;

endmodule
`default_nettype wire

/* hw/rtl/bpa_checker.sv */
// Port-level checker for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg and buddy_page_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none
module bpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [15:0] granted_page
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block did not return to idle after a result");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != bpa_pkg::STATUS_OK) |-> granted_page == '0)
        else $error("failed item carries a granted frame");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .granted_page (granted_page)
);
`default_nettype wire
